// File: rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg: shared types and constants of the packed bit-field store
// Field widths, command codes and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned POS_W      = 15;
   localparam int unsigned LEN_W      = 6;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned WORD_IDX_W = POS_W - SHIFT_W;
   localparam int unsigned END_W      = 27;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(DATA_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_READ_U = 2'd0,
      CMD_READ_S = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_RSVD   = 2'd3
   } pbs_cmd_code_type;

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic cap_lo;
      logic cap_hi;
      logic sel_hi;
      logic mem_we;
      logic load_rsp;
   } pbs_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic access;
      logic is_write;
      logic straddle;
      logic rsp_free;
   } pbs_stat_type;

endpackage

// File: rtl/pbs_if.sv
// ----------------------------------------------------------------------------
// pbs_req_if / pbs_rsp_if: valid/ready channels of the bit-field store
// Request carries one field access; response carries its result.
// ----------------------------------------------------------------------------
interface pbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbs_pkg::CMD_W-1:0]     command;
   logic [pbs_pkg::POS_W-1:0]     bit_position;
   logic [pbs_pkg::LEN_W-1:0]     field_length;
   logic [pbs_pkg::DATA_W-1:0]    write_value;

   modport source (output valid, command, bit_position, field_length, write_value,
                   input ready);
   modport sink   (input valid, command, bit_position, field_length, write_value,
                   output ready);
endinterface

interface pbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pbs_pkg::DATA_W-1:0]    read_data;
   logic                          range_error;

   modport source (output valid, read_data, range_error, input ready);
   modport sink   (input valid, read_data, range_error, output ready);
endinterface

// File: rtl/packed_bitfield_store.sv
// ----------------------------------------------------------------------------
// packed_bitfield_store: bit-field read/write over a word store
// Each request transaction reads (zero or sign extended) or writes one field
// of 1 to 32 bits anywhere in a bit array of STORE_WORDS 32-bit words; a
// field may span two adjacent words. Writes keep neighboring bits by
// read-modify-write. A field reaching past the end of the array returns
// range_error and leaves the store untouched.
// Channels: req_ch (command, bit_position, field_length, write_value) and
// rsp_ch (read_data, range_error), both valid/ready; one response per request.
// Sequencing: the single RAM port sets the pace. A skipped access goes
// straight to the response; an access reads the lower word and, for a field
// that straddles, the upper word; a write then writes each read word back.
// A new request is taken only once the last result is loaded into the output
// register. Lengths above 32 count as 32; length zero accesses nothing.
// Reset clears the sequencer and the response valid; the store itself is not
// cleared and must be written before it is read. A stalled response is held
// in the output register; the next request is still taken and its result
// waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module packed_bitfield_store #(
   parameter int unsigned STORE_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   pbs_req_if.sink     req_ch,
   pbs_rsp_if.source   rsp_ch
);

   localparam int unsigned AW = $clog2(STORE_WORDS);

   pbs_pkg::pbs_ctrl_type           ctrl;
   pbs_pkg::pbs_stat_type           stat;
   logic [AW-1:0]                   mem_addr;
   logic                            mem_we;
   logic [pbs_pkg::DATA_W-1:0]      mem_wr_data;
   logic [pbs_pkg::DATA_W-1:0]      mem_rd_data;

   pbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   pbs_dp #(
      .STORE_WORDS (STORE_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_ch.command),
      .req_bit_position (req_ch.bit_position),
      .req_field_length (req_ch.field_length),
      .req_write_value  (req_ch.write_value),
      .mem_addr         (mem_addr),
      .mem_we           (mem_we),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_read_data    (rsp_ch.read_data),
      .rsp_range_error  (rsp_ch.range_error)
   );

   pbs_ram #(
      .WIDTH (pbs_pkg::DATA_W),
      .DEPTH (STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

// File: rtl/pbs_ram.sv
// ----------------------------------------------------------------------------
// pbs_ram: generic single-port RAM
// One read or write per cycle; read data registered.
// ----------------------------------------------------------------------------
module pbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pbs_ctrl.sv
// ----------------------------------------------------------------------------
// pbs_ctrl: sequencer of the bit-field store
// Walks a transaction through read, second read and write-back, as needed.
// ----------------------------------------------------------------------------
module pbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pbs_pkg::pbs_stat_type stat,
   output pbs_pkg::pbs_ctrl_type ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE_LO,
      S_CAP_LO,
      S_CAP_HI,
      S_WR_LO,
      S_WR_HI,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               ctrl.load_item = 1'b1;
               state_in       = S_ISSUE_LO;
            end
         end
         S_ISSUE_LO: begin
            state_in = stat.access ? S_CAP_LO : S_DONE;
         end
         S_CAP_LO: begin
            ctrl.cap_lo = 1'b1;
            ctrl.sel_hi = 1'b1;   // issue the upper word read now
            if (stat.straddle) begin
               state_in = S_CAP_HI;
            end else begin
               state_in = stat.is_write ? S_WR_LO : S_DONE;
            end
         end
         S_CAP_HI: begin
            ctrl.cap_hi = 1'b1;
            state_in    = stat.is_write ? S_WR_LO : S_DONE;
         end
         S_WR_LO: begin
            ctrl.mem_we = 1'b1;
            state_in    = stat.straddle ? S_WR_HI : S_DONE;
         end
         S_WR_HI: begin
            ctrl.mem_we = 1'b1;
            ctrl.sel_hi = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (stat.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: rtl/pbs_dp.sv
// ----------------------------------------------------------------------------
// pbs_dp: datapath of the bit-field store
// Item registers, range check, word capture, field extract/merge, result
// register.
// ----------------------------------------------------------------------------
module pbs_dp #(
   parameter int unsigned STORE_WORDS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pbs_pkg::pbs_ctrl_type            ctrl,
   output pbs_pkg::pbs_stat_type            stat,
   input  logic [pbs_pkg::CMD_W-1:0]        req_command,
   input  logic [pbs_pkg::POS_W-1:0]        req_bit_position,
   input  logic [pbs_pkg::LEN_W-1:0]        req_field_length,
   input  logic [pbs_pkg::DATA_W-1:0]       req_write_value,
   output logic [$clog2(STORE_WORDS)-1:0]   mem_addr,
   output logic                             mem_we,
   output logic [pbs_pkg::DATA_W-1:0]       mem_wr_data,
   input  logic [pbs_pkg::DATA_W-1:0]       mem_rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pbs_pkg::DATA_W-1:0]       rsp_read_data,
   output logic                             rsp_range_error
);

   localparam int unsigned AW = $clog2(STORE_WORDS);
   localparam logic [pbs_pkg::END_W-1:0] TOTAL_BITS =
      pbs_pkg::END_W'(STORE_WORDS * pbs_pkg::DATA_W);

   localparam int unsigned DW  = pbs_pkg::DATA_W;
   localparam int unsigned DW2 = 2 * pbs_pkg::DATA_W;

   logic [pbs_pkg::CMD_W-1:0]  cmd_ff;
   logic [pbs_pkg::POS_W-1:0]  pos_ff;
   logic [pbs_pkg::LEN_W-1:0]  len_ff;
   logic [DW-1:0]              val_ff;
   logic [DW-1:0]              lo_ff;
   logic [DW-1:0]              hi_ff;
   logic                       rsp_valid_ff;
   logic [DW-1:0]              rsp_data_ff;
   logic                       rsp_err_ff;

   logic [pbs_pkg::LEN_W-1:0]      len_sat;
   logic                           cmd_ok;
   logic                           range_err;
   logic [pbs_pkg::END_W-1:0]      end_bit;
   logic [pbs_pkg::SHIFT_W-1:0]    shift;
   logic [pbs_pkg::WORD_IDX_W-1:0] word_idx;
   logic [pbs_pkg::WORD_IDX_W:0]   word_idx_next;
   logic [DW-1:0]                  mask;
   logic [DW2-1:0]                 both;
   logic [DW2-1:0]                 field_mask;
   logic [DW2-1:0]                 merged;
   logic [DW-1:0]                  field;
   logic [pbs_pkg::SHIFT_W-1:0]    sign_idx;
   logic [DW-1:0]                  read_val;
   logic [DW-1:0]                  rsp_data_in;

   // clamp over-long fields to a full word
   assign len_sat = (req_field_length > pbs_pkg::MAX_LEN) ? pbs_pkg::MAX_LEN
                                                           : req_field_length;

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         cmd_ff <= req_command;
         pos_ff <= req_bit_position;
         len_ff <= len_sat;
         val_ff <= req_write_value;
      end
      if (ctrl.cap_lo) begin
         lo_ff <= mem_rd_data;
         hi_ff <= '0;
      end
      if (ctrl.cap_hi) begin
         hi_ff <= mem_rd_data;
      end
   end

   assign cmd_ok    = (cmd_ff != pbs_pkg::CMD_RSVD);
   assign end_bit   = pbs_pkg::END_W'(pos_ff) + pbs_pkg::END_W'(len_ff);
   assign range_err = cmd_ok && (end_bit > TOTAL_BITS);
   assign shift     = pos_ff[pbs_pkg::SHIFT_W-1:0];
   assign word_idx  = pos_ff[pbs_pkg::POS_W-1:pbs_pkg::SHIFT_W];
   assign word_idx_next = {1'b0, word_idx} + 1'b1;

   assign stat.access   = cmd_ok && !range_err && (len_ff != '0);
   assign stat.is_write = (cmd_ff == pbs_pkg::CMD_WRITE);
   assign stat.straddle = ((pbs_pkg::LEN_W'(shift) + len_ff) > pbs_pkg::MAX_LEN);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // in-range straddling accesses keep both word indexes below STORE_WORDS
   assign mem_addr = ctrl.sel_hi ? AW'(word_idx_next) : AW'(word_idx);
   assign mem_we   = ctrl.mem_we;

   assign mask = (len_ff == pbs_pkg::MAX_LEN) ? '1
               : DW'(({{DW{1'b0}}, 1'b1} << len_ff) - 1'b1);

   assign both       = {hi_ff, lo_ff};
   assign field_mask = {{DW{1'b0}}, mask} << shift;
   assign merged     = (both & ~field_mask) | ({{DW{1'b0}}, val_ff & mask} << shift);
   assign mem_wr_data = ctrl.sel_hi ? merged[DW2-1:DW] : merged[DW-1:0];

   assign field    = DW'(both >> shift) & mask;
   assign sign_idx = pbs_pkg::SHIFT_W'(len_ff - 1'b1);
   assign read_val = ((cmd_ff == pbs_pkg::CMD_READ_S) && field[sign_idx])
                   ? (field | ~mask) : field;

   assign rsp_data_in = (stat.access && !stat.is_write) ? read_val : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= range_err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

// File: rtl/pbs_checker.sv
// ----------------------------------------------------------------------------
// pbs_checker: port-level checks of the bit-field store
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module pbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pbs_pkg::DATA_W-1:0]    rsp_read_data,
   input logic                          rsp_range_error
);

   // one transaction at a time: ready drops right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready stayed high after accept");

   // a rejected access never returns data
   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_read_data == '0))
      else $error("range error response carries data");

   // reset leaves no response pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_range_error)))
      else $error("stalled response changed");

endmodule

bind packed_bitfield_store pbs_checker u_pbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_read_data   (rsp_ch.read_data),
   .rsp_range_error (rsp_ch.range_error)
);
